// ----- design/ssw_pkg.sv -----
// Shared types, codes, glyph table and microcode for the seven-segment serial writer.
`default_nettype none

package ssw_pkg;

	// Input command codes
	localparam logic [1:0] CMD_RAW     = 2'd0;
	localparam logic [1:0] CMD_GLYPH   = 2'd1;
	localparam logic [1:0] CMD_CONTROL = 2'd2;
	localparam logic [1:0] CMD_ADDRESS = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_ON = 2'd1;

	// Frame prefixes and reset values
	localparam logic [7:0] FRAME_CONTROL = 8'h80;
	localparam logic [7:0] FRAME_ADDRESS = 8'hC0;
	localparam logic [2:0] BRIGHTNESS_RESET = 3'd7;
	localparam logic       DISPLAY_ON_RESET = 1'b1;

	// Glyph table covers codes 0x20 to 0x5A
	localparam logic [7:0] GLYPH_FIRST = 8'h20;
	localparam logic [7:0] GLYPH_LAST  = 8'h5A;
	localparam logic [7:0] CASE_FOLD   = 8'h20;
	localparam int unsigned GLYPH_COUNT = 59;
	localparam logic [7:0] GLYPH_TABLE [GLYPH_COUNT] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00,
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h6F,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h74,
		8'h04, 8'h1E, 8'h75, 8'h38, 8'h37, 8'h54, 8'h5C, 8'h73,
		8'h67, 8'h50, 8'h6C, 8'h78, 8'h1C, 8'h3E, 8'h7E, 8'h76,
		8'h6E, 8'h1B
	};

	// Byte, start and stop flags handed to the sequencer
	typedef struct packed {
		logic [7:0] frame;
		logic       start;
		logic       stop;
	} ssw_job_t;

	// Microcode sequencing operations
	localparam logic [1:0] SEQ_NEXT       = 2'd0;
	localparam logic [1:0] SEQ_LOOP_BITS  = 2'd1;
	localparam logic [1:0] SEQ_END_NOSTOP = 2'd2;
	localparam logic [1:0] SEQ_END        = 2'd3;

	// Program step addresses
	localparam int unsigned UPC_W = 4;
	localparam logic [UPC_W-1:0] STEP_START  = 4'd0;
	localparam logic [UPC_W-1:0] STEP_BIT_HI = 4'd1;
	localparam logic [UPC_W-1:0] STEP_BIT_LO = 4'd2;
	localparam logic [UPC_W-1:0] STEP_ACK0   = 4'd3;
	localparam logic [UPC_W-1:0] STEP_ACK1   = 4'd4;
	localparam logic [UPC_W-1:0] STEP_ACK2   = 4'd5;
	localparam logic [UPC_W-1:0] STEP_ACK3   = 4'd6;
	localparam logic [UPC_W-1:0] STEP_STOP0  = 4'd7;
	localparam logic [UPC_W-1:0] STEP_STOP1  = 4'd8;
	localparam logic [UPC_W-1:0] STEP_STOP2  = 4'd9;

	// One control word per step
	typedef struct packed {
		logic             clk_en;
		logic             clk_val;
		logic             dat_en;
		logic             dat_from_bit;
		logic             dat_val;
		logic [1:0]       op;
		logic [UPC_W-1:0] target;
	} ssw_uword_t;

	// Look up a segment pattern, folding lower case and blanking unknown codes
	function automatic logic [7:0] ssw_glyph(input logic [7:0] c);
		logic [7:0] v;
		logic [7:0] offs;
		v = c;
		if (v > GLYPH_LAST) begin
			v = v - CASE_FOLD;
		end
		offs = v - GLYPH_FIRST;
		if (v < GLYPH_FIRST || v > GLYPH_LAST) begin
			return 8'h00;
		end
		return GLYPH_TABLE[offs[5:0]];
	endfunction

	// Microcode ROM
	function automatic ssw_uword_t ssw_ucode(input logic [UPC_W-1:0] upc);
		ssw_uword_t w;
		w = '0;
		w.op = SEQ_NEXT;
		case (upc)
			STEP_START: begin
				w.dat_en = 1'b1; w.dat_val = 1'b1;
			end
			STEP_BIT_HI: begin
				w.clk_en = 1'b1; w.clk_val = 1'b1;
				w.dat_en = 1'b1; w.dat_from_bit = 1'b1;
			end
			STEP_BIT_LO: begin
				w.clk_en = 1'b1; w.clk_val = 1'b0;
				w.op = SEQ_LOOP_BITS; w.target = STEP_BIT_HI;
			end
			STEP_ACK0: begin
				w.clk_en = 1'b1; w.clk_val = 1'b1;
				w.dat_en = 1'b1; w.dat_val = 1'b0;
			end
			STEP_ACK1: begin
				w.clk_en = 1'b1; w.clk_val = 1'b0;
			end
			STEP_ACK2: begin
				w.dat_en = 1'b1; w.dat_val = 1'b1;
			end
			STEP_ACK3: begin
				w.clk_en = 1'b1; w.clk_val = 1'b1;
				w.op = SEQ_END_NOSTOP;
			end
			STEP_STOP0: begin
				w.dat_en = 1'b1; w.dat_val = 1'b1;
			end
			STEP_STOP1: begin
				w.clk_en = 1'b1; w.clk_val = 1'b0;
			end
			STEP_STOP2: begin
				w.dat_en = 1'b1; w.dat_val = 1'b0;
				w.op = SEQ_END;
			end
			default: begin
				w.op = SEQ_END;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- design/ssw_frame.sv -----
// Frame builder: picks the byte to send and the start and stop flags for one word.
`default_nettype none

module ssw_frame (
	input  wire logic [1:0]       command,
	input  wire logic [7:0]       byte_value,
	input  wire logic             start_before,
	input  wire logic             stop_after,
	input  wire logic [2:0]       brightness,
	input  wire logic             display_on,
	output ssw_pkg::ssw_job_t     job
);
	import ssw_pkg::*;

	// Build the frame for each command
	always_comb begin
		job = '0;
		unique case (command)
			CMD_RAW: begin
				job.frame = byte_value;
				job.start = start_before;
				job.stop  = stop_after;
			end
			CMD_GLYPH: begin
				job.frame = ssw_glyph(byte_value);
				job.start = start_before;
				job.stop  = stop_after;
			end
			CMD_CONTROL: begin
				job.frame = FRAME_CONTROL | {4'b0000, display_on, brightness};
				job.start = 1'b1;
				job.stop  = 1'b1;
			end
			CMD_ADDRESS: begin
				job.frame = FRAME_ADDRESS | {5'b00000, byte_value[2:0]};
				job.start = 1'b1;
				job.stop  = 1'b0;
			end
			default: begin
				job = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/ssw_sequencer.sv -----
// Microcoded sequencer: steps through the pin program and drives the output register.
`default_nettype none

module ssw_sequencer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  ssw_pkg::ssw_job_t     job,
	output logic                  busy,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  clock_pin,
	output logic                  data_pin,
	output logic                  last
);
	import ssw_pkg::*;

	logic             busy_q;
	logic [UPC_W-1:0] upc_q;
	logic [2:0]       bit_q;
	logic [7:0]       frame_q;
	logic             stop_q;
	logic             clk_q;
	logic             dat_q;
	logic             out_valid_q;
	logic             last_q;
	ssw_uword_t       uw;
	logic             step;
	logic             done;

	// Decode the current control word
	assign uw   = ssw_ucode(upc_q);
	assign step = busy_q && (!out_valid_q || out_ready);

	always_comb begin
		case (uw.op)
			SEQ_END_NOSTOP: done = !stop_q;
			SEQ_END:        done = 1'b1;
			default:        done = 1'b0;
		endcase
	end

	// Advance the step counter, pins and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			upc_q       <= STEP_START;
			bit_q       <= '0;
			stop_q      <= 1'b0;
			clk_q       <= 1'b0;
			dat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (load) begin
				busy_q  <= 1'b1;
				upc_q   <= job.start ? STEP_START : STEP_BIT_HI;
				bit_q   <= '0;
				stop_q  <= job.stop;
				if (out_valid_q && out_ready) begin
					out_valid_q <= 1'b0;
				end
			end else if (step) begin
				out_valid_q <= 1'b1;
				last_q      <= done;
				if (uw.clk_en) begin
					clk_q <= uw.clk_val;
				end
				if (uw.dat_en) begin
					dat_q <= uw.dat_from_bit ? ~frame_q[0] : uw.dat_val;
				end
				if (done) begin
					busy_q <= 1'b0;
				end
				if (uw.op == SEQ_LOOP_BITS) begin
					bit_q <= bit_q + 3'd1;
					upc_q <= (bit_q != 3'd7) ? uw.target : upc_q + 4'd1;
				end else begin
					upc_q <= upc_q + 4'd1;
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the byte, drop the sent bit at each clock-low step
	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= job.frame;
		end else if (step && uw.op == SEQ_LOOP_BITS) begin
			frame_q <= {1'b0, frame_q[7:1]};
		end
	end

	assign busy      = busy_q;
	assign out_valid = out_valid_q;
	assign clock_pin = clk_q;
	assign data_pin  = dat_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ----- design/segment_display_serial_writer.sv -----
// The first pin step of a word is registered after the word is taken, once the previous
// last step, if still shown, is accepted. Throughput: 20 to 24 steps per word, one per
// cycle while out_ready is high, set by the single microcode step counter; the next word
// can be taken while the last step is still shown, as busy drops when it is registered.
// Reset: clock and data pins low, brightness 7, display on, sequencer idle.
`default_nettype none

module segment_display_serial_writer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       command,
	input  wire logic [7:0]                       byte_value,
	input  wire logic                             start_before,
	input  wire logic                             stop_after,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  clock_pin,
	output logic                                  data_pin,
	output logic                                  last,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [ssw_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [2:0]                       cfg_data
);
	import ssw_pkg::*;

	logic [2:0] brightness_q;
	logic       display_on_q;
	ssw_job_t   job;
	logic       busy;
	logic       load;

	// Configuration registers, unknown indexes dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHTNESS_RESET;
			display_on_q <= DISPLAY_ON_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_BRIGHTNESS) begin
				brightness_q <= cfg_data;
			end else if (cfg_index == REG_DISPLAY_ON) begin
				display_on_q <= cfg_data[0];
			end
		end
	end

	// Take a word whenever the sequencer is idle
	assign in_ready = !busy;
	assign load     = in_valid && in_ready;

	ssw_frame u_frame (
		.command      (command),
		.byte_value   (byte_value),
		.start_before (start_before),
		.stop_after   (stop_after),
		.brightness   (brightness_q),
		.display_on   (display_on_q),
		.job          (job)
	);

	ssw_sequencer u_sequencer (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.job       (job),
		.busy      (busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.clock_pin (clock_pin),
		.data_pin  (data_pin),
		.last      (last)
	);

`ifndef ASSERT_OFF
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> !in_ready)
		else $error("sequencer idle right after taking a word");

	a_busy_before_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> !in_ready)
		else $error("sequencer freed while a middle step is still shown");

	a_free_only_by_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> (out_valid && last))
		else $error("sequencer freed without a last step");
`endif

endmodule

`default_nettype wire

// ----- sim/segment_pin_checker.sv -----
// Pin-step predictor and scoreboard for the seven-segment serial writer.
`timescale 1ns / 100ps

module segment_pin_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_ready,
	input  wire logic [1:0]                      command,
	input  wire logic [7:0]                      byte_value,
	input  wire logic                            start_before,
	input  wire logic                            stop_after,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire logic                            clock_pin,
	input  wire logic                            data_pin,
	input  wire logic                            last,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [ssw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [2:0]                      cfg_data,
	output int                                   failures,
	output int                                   pending
);
	import ssw_pkg::*;

	// Segment patterns for characters 0x20 up to 0x5A
	localparam logic [7:0] SEGMENTS [59] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00,
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h6F,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h74,
		8'h04, 8'h1E, 8'h75, 8'h38, 8'h37, 8'h54, 8'h5C, 8'h73,
		8'h67, 8'h50, 8'h6C, 8'h78, 8'h1C, 8'h3E, 8'h7E, 8'h76,
		8'h6E, 8'h1B
	};

	typedef struct packed {
		logic clk_lvl;
		logic dat_lvl;
		logic fin;
	} pin_step_t;

	pin_step_t  pin_steps [$];
	logic       clk_lvl;
	logic       dat_lvl;
	logic [2:0] bright;
	logic       disp_on;

	// Fold lower case, blank anything outside the table
	function automatic logic [7:0] segment_pattern(input logic [7:0] ch);
		int v;
		v = ch;
		if (v > GLYPH_LAST) begin
			v = v - CASE_FOLD;
		end
		if (v < GLYPH_FIRST || v > GLYPH_LAST) begin
			return 8'h00;
		end
		return SEGMENTS[v - GLYPH_FIRST];
	endfunction

	// Drive the selected pins and queue the resulting levels
	task automatic put_step(input bit drive_clk, input bit clk_val,
			input bit drive_dat, input bit dat_val);
		if (drive_clk) begin
			clk_lvl = clk_val;
		end
		if (drive_dat) begin
			dat_lvl = dat_val;
		end
		pin_steps.push_back('{clk_lvl, dat_lvl, 1'b0});
	endtask

	task automatic put_start();
		put_step(1'b0, 1'b0, 1'b1, 1'b1);
	endtask

	task automatic put_stop();
		put_step(1'b0, 1'b0, 1'b1, 1'b1);
		put_step(1'b1, 1'b0, 1'b0, 1'b0);
		put_step(1'b0, 1'b0, 1'b1, 1'b0);
	endtask

	// Shift the byte out LSB first on an inverted data line, then the forced acknowledge
	task automatic put_frame(input logic [7:0] b);
		for (int i = 0; i < 8; i++) begin
			put_step(1'b1, 1'b1, 1'b1, !b[i]);
			put_step(1'b1, 1'b0, 1'b0, 1'b0);
		end
		put_step(1'b1, 1'b1, 1'b1, 1'b0);
		put_step(1'b1, 1'b0, 1'b0, 1'b0);
		put_step(1'b0, 1'b0, 1'b1, 1'b1);
		put_step(1'b1, 1'b1, 1'b0, 1'b0);
	endtask

	task automatic predict_word(input logic [1:0] cmd, input logic [7:0] val,
			input logic sb, input logic sa);
		logic [7:0] b;
		case (cmd)
			CMD_CONTROL: begin
				put_start();
				put_frame(FRAME_CONTROL | {4'b0000, disp_on, bright});
				put_stop();
			end
			CMD_ADDRESS: begin
				put_start();
				put_frame(FRAME_ADDRESS | {5'b00000, val[2:0]});
			end
			default: begin
				b = (cmd == CMD_GLYPH) ? segment_pattern(val) : val;
				if (sb) begin
					put_start();
				end
				put_frame(b);
				if (sa) begin
					put_stop();
				end
			end
		endcase
		pin_steps[pin_steps.size()-1].fin = 1'b1;
	endtask

	// Compare output words first, then apply register writes, then predict new words
	always @(posedge clk or negedge arst_n) begin : watch
		pin_step_t due;
		if (!arst_n) begin
			pin_steps.delete();
			clk_lvl  = 1'b0;
			dat_lvl  = 1'b0;
			bright   = BRIGHTNESS_RESET;
			disp_on  = DISPLAY_ON_RESET;
			failures = 0;
			pending  = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pin_steps.size() == 0) begin
					failures++;
					if (failures <= 10) begin
						$display("%0t: unexpected output word: clk %0b dat %0b last %0b",
							$time, clock_pin, data_pin, last);
					end
				end else begin
					due = pin_steps.pop_front();
					if (due != {clock_pin, data_pin, last}) begin
						failures++;
						if (failures <= 10) begin
							$display("%0t: output word mismatch: expected clk %0b dat %0b last %0b, got clk %0b dat %0b last %0b",
								$time, due.clk_lvl, due.dat_lvl, due.fin,
								clock_pin, data_pin, last);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BRIGHTNESS: bright = cfg_data;
					REG_DISPLAY_ON: disp_on = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				predict_word(command, byte_value, start_before, stop_after);
			end
			pending = pin_steps.size();
		end
	end

endmodule

// ----- sim/tb_segment_display_serial_writer.sv -----
// Stimulus and verdict for the seven-segment serial writer testbench.
`timescale 1ns / 100ps

module tb_segment_display_serial_writer;
	import ssw_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_WORDS = 250;
	localparam int CALM_FROM = 220;
	localparam logic [CFG_INDEX_W-1:0] SPARE_REG_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] SPARE_REG_HI = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [1:0]             command = CMD_RAW;
	logic [7:0]             byte_value = 8'h00;
	logic                   start_before = 1'b0;
	logic                   stop_after = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   clock_pin;
	logic                   data_pin;
	logic                   last;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_BRIGHTNESS;
	logic [2:0]             cfg_data = 3'd0;

	int   failures;
	int   pending;
	int   words_sent = 0;
	int   stall_left = 0;
	int   quiet_cycles = 0;
	logic idle_on = 1'b1;

	always #1 clk = ~clk;

	segment_display_serial_writer uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .byte_value(byte_value),
		.start_before(start_before), .stop_after(stop_after),
		.out_valid(out_valid), .out_ready(out_ready),
		.clock_pin(clock_pin), .data_pin(data_pin), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	segment_pin_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .byte_value(byte_value),
		.start_before(start_before), .stop_after(stop_after),
		.out_valid(out_valid), .out_ready(out_ready),
		.clock_pin(clock_pin), .data_pin(data_pin), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.failures(failures), .pending(pending)
	);

	// Stall the output side in random bursts while idle_on is set
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left <= int'($urandom_range(0, 15));
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// End the run when no word moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("tb_segment_display_serial_writer: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one input word and hold it until taken; valid stays high afterwards
	task automatic send_word(input logic [1:0] cmd, input logic [7:0] val,
			input logic sb, input logic sa);
		command <= cmd;
		byte_value <= val;
		start_before <= sb;
		stop_after <= sa;
		in_valid <= 1'b1;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		words_sent++;
	endtask

	// Sometimes, while idle_on is set, drop input valid for a random burst
	task automatic pause_maybe();
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Drop input valid and wait until every predicted pin step has come out
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Write one register with the block idle
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [2:0] val);
		drain();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly characters the table can show, sometimes any byte
	function automatic logic [7:0] pick_char();
		if ($urandom_range(0, 4) == 0) begin
			return 8'($urandom_range(0, 255));
		end
		return 8'($urandom_range(8'h20, 8'h7A));
	endfunction

	// Typical display update: optional control frame, address frame, then a run of bytes
	task automatic send_display_update();
		int n;
		logic [1:0] kind;
		n = $urandom_range(1, 6);
		if ($urandom_range(0, 1) == 1) begin
			send_word(CMD_CONTROL, 8'($urandom), 1'($urandom), 1'($urandom));
			pause_maybe();
		end
		send_word(CMD_ADDRESS, 8'($urandom_range(0, 255)), 1'($urandom), 1'($urandom));
		for (int i = 0; i < n; i++) begin
			pause_maybe();
			kind = ($urandom_range(0, 2) == 0) ? CMD_RAW : CMD_GLYPH;
			send_word(kind, pick_char(), 1'b0, i == n - 1);
		end
	endtask

	task automatic random_settings();
		logic [2:0] level;
		case ($urandom_range(0, 3))
			0: level = 3'd0;
			1: level = 3'd7;
			default: level = 3'($urandom_range(0, 7));
		endcase
		write_reg(REG_BRIGHTNESS, level);
		write_reg(REG_DISPLAY_ON, 3'($urandom_range(0, 7)));
		if ($urandom_range(0, 3) == 0) begin
			write_reg($urandom_range(0, 1) ? SPARE_REG_HI : SPARE_REG_LO,
				3'($urandom_range(0, 7)));
		end
	endtask

	initial begin
		int last_cfg;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: raw extremes, glyph edges and case folding, both frame kinds
		send_word(CMD_RAW, 8'h00, 1'b1, 1'b1);
		send_word(CMD_RAW, 8'hFF, 1'b0, 1'b0);
		send_word(CMD_RAW, 8'hA5, 1'b1, 1'b0);
		send_word(CMD_RAW, 8'h5A, 1'b0, 1'b1);
		send_word(CMD_GLYPH, 8'h30, 1'b1, 1'b0);
		send_word(CMD_GLYPH, 8'h41, 1'b0, 1'b0);
		send_word(CMD_GLYPH, 8'h61, 1'b0, 1'b0);
		send_word(CMD_GLYPH, 8'h7A, 1'b0, 1'b0);
		send_word(CMD_GLYPH, 8'h5A, 1'b0, 1'b0);
		send_word(CMD_GLYPH, 8'h5B, 1'b0, 1'b0);
		send_word(CMD_GLYPH, 8'h7B, 1'b0, 1'b0);
		send_word(CMD_GLYPH, 8'h1F, 1'b0, 1'b0);
		send_word(CMD_GLYPH, 8'h20, 1'b0, 1'b0);
		send_word(CMD_GLYPH, 8'h80, 1'b0, 1'b0);
		send_word(CMD_GLYPH, 8'hFF, 1'b0, 1'b1);
		send_word(CMD_CONTROL, 8'hFF, 1'b1, 1'b1);
		send_word(CMD_CONTROL, 8'h00, 1'b0, 1'b0);
		send_word(CMD_ADDRESS, 8'h00, 1'b0, 1'b0);
		send_word(CMD_ADDRESS, 8'hFF, 1'b1, 1'b1);
		send_word(CMD_ADDRESS, 8'h05, 1'b0, 1'b1);

		// Control frame at the lowest setting, via ignored indexes, then full brightness
		write_reg(REG_BRIGHTNESS, 3'd0);
		write_reg(REG_DISPLAY_ON, 3'd0);
		send_word(CMD_CONTROL, 8'h00, 1'b0, 1'b0);
		write_reg(SPARE_REG_LO, 3'd7);
		write_reg(SPARE_REG_HI, 3'd5);
		send_word(CMD_CONTROL, 8'h00, 1'b0, 1'b0);
		write_reg(REG_BRIGHTNESS, 3'd7);
		write_reg(REG_DISPLAY_ON, 3'd6);
		send_word(CMD_CONTROL, 8'h00, 1'b0, 1'b0);

		// Random: mostly well-formed display updates, some loose words
		last_cfg = words_sent;
		while (words_sent < RANDOM_WORDS + 23) begin
			if (words_sent >= CALM_FROM) begin
				idle_on <= 1'b0;
			end
			if (words_sent - last_cfg >= 40) begin
				random_settings();
				last_cfg = words_sent;
				if (words_sent < CALM_FROM) begin
					idle_on <= ($urandom_range(0, 3) != 0);
				end
			end
			pause_maybe();
			if ($urandom_range(0, 9) < 7) begin
				send_display_update();
			end else begin
				send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					1'($urandom), 1'($urandom));
			end
		end

		// Let everything drain, then allow a short latency margin
		drain();
		repeat (30) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("tb_segment_display_serial_writer: PASS");
		end else begin
			$display("tb_segment_display_serial_writer: FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/ssw_pkg.sv
design/ssw_frame.sv
design/ssw_sequencer.sv
design/segment_display_serial_writer.sv
sim/segment_pin_checker.sv
sim/tb_segment_display_serial_writer.sv
